@@ rtl/tbp_pkg.sv @@
// Package for the tournament branch predictor: counter constants, item kind
// codes, default sizes and the counter training functions.
// No dependencies.
package tbp_pkg;

   localparam int unsigned ADDR_INDEX_BITS_DEF  = 8;
   localparam int unsigned LOCAL_HIST_BITS_DEF  = 6;
   localparam int unsigned GLOBAL_HIST_BITS_DEF = 12;
   localparam int unsigned BRANCH_ADDR_W        = 32;

   typedef logic [2:0] ctr_type;

   localparam ctr_type CTR_MIN           = 3'd0;
   localparam ctr_type CTR_INIT          = 3'd3;
   localparam ctr_type CTR_TAKEN         = 3'd4;
   localparam ctr_type CTR_MAX           = 3'd7;
   localparam ctr_type CHOOSE_GSHARE_MAX = 3'd3;

   typedef enum logic {
      KIND_LOOKUP = 1'b0,
      KIND_UPDATE = 1'b1
   } kind_type;

   // saturating step toward the outcome
   function automatic ctr_type ctr_train(ctr_type c, logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + 3'd1;
      end else begin
         if (c != CTR_MIN) r = c - 3'd1;
      end
      return r;
   endfunction

   // down when only gshare was right, up when only local was right
   function automatic ctr_type chooser_next(ctr_type c, logic g_ok, logic l_ok);
      ctr_type r;
      r = c;
      if (g_ok && !l_ok) begin
         if (c != CTR_MIN) r = c - 3'd1;
      end else if (l_ok && !g_ok) begin
         if (c != CTR_MAX) r = c + 3'd1;
      end
      return r;
   endfunction

endpackage

@@ rtl/tbp_if.sv @@
// Channel interfaces of the tournament branch predictor: request items in,
// prediction items out. Depends on tbp_pkg.
interface tbp_req_if import tbp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [BRANCH_ADDR_W-1:0] branch_addr;
   logic                     taken;

   modport source (output valid, kind, branch_addr, taken, input ready);
   modport sink   (input valid, kind, branch_addr, taken, output ready);
endinterface

interface tbp_rsp_if import tbp_pkg::*; ();
   logic valid;
   logic ready;
   logic prediction;

   modport source (output valid, prediction, input ready);
   modport sink   (input valid, prediction, output ready);
endinterface

@@ rtl/tbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the new data. No dependencies.
module tbp_ram #(
   parameter int unsigned WIDTH = 3,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tbp_init.sv @@
// Post-reset clearing sequencer: sweeps every table address once.
// Depends on nothing but its parameter.
module tbp_init #(
   parameter int unsigned SWEEP_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  busy,
   output logic [SWEEP_BITS-1:0] index
);

   logic                  busy_ff, busy_in;
   logic [SWEEP_BITS-1:0] idx_ff, idx_in;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (busy_ff) begin
         idx_in = idx_ff + 1'b1;
         // last address written this cycle
         if (&idx_ff) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   assign busy  = busy_ff;
   assign index = idx_ff;

endmodule

@@ rtl/tournament_branch_predictor.sv @@
// Tournament branch predictor (local history + gshare, per-address chooser).
// Uses tbp_pkg, tbp_req_if, tbp_rsp_if, tbp_ram and tbp_init.
//
// Request channel req_if carries lookup and update items; a lookup yields one
// prediction item on rsp_if, an update yields none. An update trains with the
// guesses of the most recent lookup.
// A lookup passes stage 1, stage 2 and the result register before its
// prediction shows on rsp_if. Throughput: one item per cycle while no result
// waits on rsp_if, lookups and updates mixed freely; each table is a RAM
// read once per item (chooser, gshare and local history at accept, local
// counter one stage later); local history is written in stage 1, counters
// in the last stage with a one-deep bypass. Reset: control state clears,
// then a clearing pass over all 2**max(ADDR_INDEX_BITS+LOCAL_HIST_BITS,
// GLOBAL_HIST_BITS) addresses (16384 at the defaults) loads every counter
// with 3 and every local history with 0; req_if.ready is low during the pass.
// Stall: while a prediction waits on rsp_if, the whole pipeline holds and
// req_if.ready drops; nothing is lost or repeated.
module tournament_branch_predictor import tbp_pkg::*; #(
   parameter int unsigned ADDR_INDEX_BITS  = ADDR_INDEX_BITS_DEF,
   parameter int unsigned LOCAL_HIST_BITS  = LOCAL_HIST_BITS_DEF,
   parameter int unsigned GLOBAL_HIST_BITS = GLOBAL_HIST_BITS_DEF
) (
   input logic clock,
   input logic reset,
   tbp_req_if.sink   req_if,
   tbp_rsp_if.source rsp_if
);

   localparam int unsigned A_BITS     = ADDR_INDEX_BITS;
   localparam int unsigned L_BITS     = LOCAL_HIST_BITS;
   localparam int unsigned G_BITS     = GLOBAL_HIST_BITS;
   localparam int unsigned LIDX_BITS  = A_BITS + L_BITS;
   localparam int unsigned SWEEP_BITS = (LIDX_BITS > G_BITS) ? LIDX_BITS : G_BITS;
   localparam int unsigned SLOTS      = 1 << A_BITS;
   localparam int unsigned LCTRS      = 1 << LIDX_BITS;
   localparam int unsigned GCTRS      = 1 << G_BITS;

   // clearing pass
   logic                  clr_busy;
   logic [SWEEP_BITS-1:0] clr_idx;

   // handshake
   logic adv;
   logic acc;

   // accept-side signals
   logic [A_BITS-1:0] a_slot;
   logic [G_BITS-1:0] a_gidx;
   logic [G_BITS-1:0] ghist_ff, ghist_in;

   // stage 1
   logic              s1_vld_ff;
   kind_type          s1_kind_ff;
   logic [A_BITS-1:0] s1_slot_ff;
   logic [G_BITS-1:0] s1_gidx_ff;
   logic              s1_taken_ff;
   logic [L_BITS-1:0] lht_rd;
   ctr_type           cho_rd;
   ctr_type           gct_rd;
   logic [LIDX_BITS-1:0] s1_lidx;
   logic              lht_we;
   logic [A_BITS-1:0] lht_wa;
   logic [L_BITS-1:0] lht_wd;

   // stage 2
   logic                 s2_vld_ff;
   kind_type             s2_kind_ff;
   logic [A_BITS-1:0]    s2_slot_ff;
   logic [G_BITS-1:0]    s2_gidx_ff;
   logic [LIDX_BITS-1:0] s2_lidx_ff;
   logic                 s2_taken_ff;
   ctr_type              s2_cho_ff, s2_cho_in;
   ctr_type              s2_gct_ff, s2_gct_in;
   ctr_type              lct_rd;
   logic                 g_guess, l_guess, pred;
   ctr_type              cho_new, gct_new, lct_new;
   logic                 s2_upd;

   // latched guesses of the latest lookup
   logic last_g_ff, last_g_in;
   logic last_l_ff, last_l_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_pred_ff, rsp_pred_in;

   // RAM write ports
   logic                 cho_we, gct_we, lct_we;
   logic [A_BITS-1:0]    cho_wa;
   logic [G_BITS-1:0]    gct_wa;
   logic [LIDX_BITS-1:0] lct_wa;
   ctr_type              cho_wd, gct_wd, lct_wd;

   tbp_init #(.SWEEP_BITS(SWEEP_BITS)) u_init (
      .clock (clock),
      .reset (reset),
      .busy  (clr_busy),
      .index (clr_idx)
   );

   // the whole pipeline advances together, held only by a waiting result
   assign adv          = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !clr_busy && adv;
   assign acc          = req_if.valid && req_if.ready;

   assign a_slot = req_if.branch_addr[A_BITS-1:0];
   assign a_gidx = req_if.branch_addr[G_BITS-1:0] ^ ghist_ff;

   // global history moves as soon as an update is accepted
   always_comb begin
      ghist_in = ghist_ff;
      if (acc && (kind_type'(req_if.kind) == KIND_UPDATE)) begin
         ghist_in = G_BITS'({ghist_ff, req_if.taken});
      end
   end

   // stage 1: local history known, issue local counter read
   assign s1_lidx = {s1_slot_ff, lht_rd};

   assign lht_we = clr_busy || (adv && s1_vld_ff && (s1_kind_ff == KIND_UPDATE));
   assign lht_wa = clr_busy ? clr_idx[A_BITS-1:0] : s1_slot_ff;
   assign lht_wd = clr_busy ? '0 : L_BITS'({lht_rd, s1_taken_ff});

   // stage 2: guesses, training values
   assign g_guess = (s2_gct_ff >= CTR_TAKEN);
   assign l_guess = (lct_rd >= CTR_TAKEN);
   assign pred    = (s2_cho_ff <= CHOOSE_GSHARE_MAX) ? g_guess : l_guess;

   assign cho_new = chooser_next(s2_cho_ff, s2_taken_ff == last_g_ff,
                                 s2_taken_ff == last_l_ff);
   assign gct_new = ctr_train(s2_gct_ff, s2_taken_ff);
   assign lct_new = ctr_train(lct_rd, s2_taken_ff);

   assign s2_upd = adv && s2_vld_ff && (s2_kind_ff == KIND_UPDATE);

   // bypass the stage 2 write into the item moving up behind it
   always_comb begin
      s2_cho_in = cho_rd;
      s2_gct_in = gct_rd;
      if (s2_upd && (s2_slot_ff == s1_slot_ff)) s2_cho_in = cho_new;
      if (s2_upd && (s2_gidx_ff == s1_gidx_ff)) s2_gct_in = gct_new;
   end

   assign cho_we = clr_busy || s2_upd;
   assign cho_wa = clr_busy ? clr_idx[A_BITS-1:0] : s2_slot_ff;
   assign cho_wd = clr_busy ? CTR_INIT : cho_new;
   assign gct_we = clr_busy || s2_upd;
   assign gct_wa = clr_busy ? clr_idx[G_BITS-1:0] : s2_gidx_ff;
   assign gct_wd = clr_busy ? CTR_INIT : gct_new;
   assign lct_we = clr_busy || s2_upd;
   assign lct_wa = clr_busy ? clr_idx[LIDX_BITS-1:0] : s2_lidx_ff;
   assign lct_wd = clr_busy ? CTR_INIT : lct_new;

   always_comb begin
      last_g_in    = last_g_ff;
      last_l_in    = last_l_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pred_in  = rsp_pred_ff;
      if (adv) begin
         rsp_valid_in = s2_vld_ff && (s2_kind_ff == KIND_LOOKUP);
         rsp_pred_in  = pred;
         if (s2_vld_ff && (s2_kind_ff == KIND_LOOKUP)) begin
            last_g_in = g_guess;
            last_l_in = l_guess;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ghist_ff     <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         last_g_ff    <= 1'b0;
         last_l_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ghist_ff     <= ghist_in;
         last_g_ff    <= last_g_in;
         last_l_ff    <= last_l_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            s1_vld_ff <= acc;
            s2_vld_ff <= s1_vld_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      rsp_pred_ff <= rsp_pred_in;
      if (adv) begin
         s1_kind_ff  <= kind_type'(req_if.kind);
         s1_slot_ff  <= a_slot;
         s1_gidx_ff  <= a_gidx;
         s1_taken_ff <= req_if.taken;
         s2_kind_ff  <= s1_kind_ff;
         s2_slot_ff  <= s1_slot_ff;
         s2_gidx_ff  <= s1_gidx_ff;
         s2_lidx_ff  <= s1_lidx;
         s2_taken_ff <= s1_taken_ff;
         s2_cho_ff   <= s2_cho_in;
         s2_gct_ff   <= s2_gct_in;
      end
   end

   tbp_ram #(.WIDTH(L_BITS), .DEPTH(SLOTS)) u_lht (
      .clock   (clock),
      .wr_en   (lht_we),
      .wr_addr (lht_wa),
      .wr_data (lht_wd),
      .rd_en   (adv),
      .rd_addr (a_slot),
      .rd_data (lht_rd)
   );

   tbp_ram #(.WIDTH($bits(ctr_type)), .DEPTH(SLOTS)) u_chooser (
      .clock   (clock),
      .wr_en   (cho_we),
      .wr_addr (cho_wa),
      .wr_data (cho_wd),
      .rd_en   (adv),
      .rd_addr (a_slot),
      .rd_data (cho_rd)
   );

   tbp_ram #(.WIDTH($bits(ctr_type)), .DEPTH(GCTRS)) u_gshare (
      .clock   (clock),
      .wr_en   (gct_we),
      .wr_addr (gct_wa),
      .wr_data (gct_wd),
      .rd_en   (adv),
      .rd_addr (a_gidx),
      .rd_data (gct_rd)
   );

   tbp_ram #(.WIDTH($bits(ctr_type)), .DEPTH(LCTRS)) u_local (
      .clock   (clock),
      .wr_en   (lct_we),
      .wr_addr (lct_wa),
      .wr_data (lct_wd),
      .rd_en   (adv),
      .rd_addr (s1_lidx),
      .rd_data (lct_rd)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.prediction = rsp_pred_ff;

endmodule

@@ rtl/tbp_checker.sv @@
// Port-level checks for the tournament branch predictor, bound to the top.
// Depends on tournament_branch_predictor.
module tbp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_prediction
);

   // a waiting prediction holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prediction))
      else $error("prediction changed while stalled");

   // a stalled result freezes the pipeline, so no item is taken
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while result stalled");

   // reset empties the result register and starts the clearing pass
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("not cleared after reset");

   // tables are still being cleared when reset drops
   a_clear_pass: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready && !(req_valid && req_ready))
      else $error("item accepted before clearing pass");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_prediction (rsp_if.prediction)
);

@@ tb/tb_tournament_branch_predictor.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for tournament_branch_predictor: directed table then
// random branch streams, checked against a local predictor of the tables.
// Depends on tbp_pkg, tbp_req_if, tbp_rsp_if and the predictor RTL.
module tb_tournament_branch_predictor;
   import tbp_pkg::*;

   localparam int unsigned AIB          = ADDR_INDEX_BITS_DEF;
   localparam int unsigned LHB          = LOCAL_HIST_BITS_DEF;
   localparam int unsigned GHB          = GLOBAL_HIST_BITS_DEF;
   localparam int unsigned SLOTS        = 1 << AIB;
   localparam int unsigned LOCAL_CTRS   = 1 << (AIB + LHB);
   localparam int unsigned GSHARE_CTRS  = 1 << GHB;
   localparam int          DIRECTED_ROWS = 25;
   localparam int          RANDOM_ITEMS  = 1000;
   localparam int          IDLE_PCT      = 36;
   localparam int          BRANCHES      = 16;
   localparam int          CYCLE_LIMIT   = 400000;

   typedef struct packed {
      kind_type                 kind;
      logic [BRANCH_ADDR_W-1:0] addr;
      logic                     taken;
      logic                     fixed;      // expected prediction typed in below
      logic                     fixed_pred;
   } stim_row_type;

   // Opens with an update before any lookup, so the reset guesses are used.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{KIND_UPDATE, 32'h0000_0012, 1'b1, 1'b0, 1'b0},
      '{KIND_LOOKUP, 32'h0000_0000, 1'b0, 1'b1, 1'b0},
      '{KIND_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
      '{KIND_LOOKUP, 32'h8000_0012, 1'b0, 1'b1, 1'b0},
      '{KIND_UPDATE, 32'h8000_0012, 1'b1, 1'b0, 1'b0},
      '{KIND_LOOKUP, 32'h0000_0012, 1'b1, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'h0000_0012, 1'b1, 1'b0, 1'b0},
      '{KIND_LOOKUP, 32'h5A5A_0012, 1'b0, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'h0000_0012, 1'b1, 1'b0, 1'b0},
      '{KIND_LOOKUP, 32'h0000_0012, 1'b0, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'hA5A5_0012, 1'b1, 1'b0, 1'b0},
      '{KIND_LOOKUP, 32'h0000_0012, 1'b0, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'h0000_0012, 1'b1, 1'b0, 1'b0},
      '{KIND_LOOKUP, 32'h0000_0012, 1'b0, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'h0000_0012, 1'b1, 1'b0, 1'b0},
      '{KIND_LOOKUP, 32'h0000_0034, 1'b0, 1'b0, 1'b0},
      // update at another address than the lookup
      '{KIND_UPDATE, 32'h0000_0056, 1'b0, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0},
      '{KIND_LOOKUP, 32'h0000_0FFF, 1'b1, 1'b0, 1'b0},
      '{KIND_UPDATE, 32'h0000_0FFF, 1'b0, 1'b0, 1'b0}
   };

   logic clock;
   logic reset;

   tbp_req_if req_if ();
   tbp_rsp_if rsp_if ();

   tournament_branch_predictor dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // predictor state
   logic [LHB-1:0] slot_history [SLOTS];
   ctr_type        local_ctr    [LOCAL_CTRS];
   ctr_type        gshare_ctr   [GSHARE_CTRS];
   ctr_type        chooser      [SLOTS];
   logic [GHB-1:0] path_history;
   logic           gshare_guess;
   logic           local_guess;

   logic pending_predictions [$];
   int   bad_predictions;
   int   items_accepted;
   int   cycle_count;
   logic calm;
   logic hold_rsp;

   // branch streams for the random part
   logic [BRANCH_ADDR_W-1:0] stream_addr   [BRANCHES];
   int                       stream_mode   [BRANCHES];
   int                       stream_period [BRANCHES];
   int                       stream_iter   [BRANCHES];

   function automatic ctr_type saturate_step(ctr_type c, logic up);
      if (up) return (c == 3'd7) ? c : c + 3'd1;
      return (c == 3'd0) ? c : c - 3'd1;
   endfunction

   function automatic void clear_tables();
      foreach (slot_history[i]) slot_history[i] = '0;
      foreach (local_ctr[i]) local_ctr[i] = CTR_INIT;
      foreach (gshare_ctr[i]) gshare_ctr[i] = CTR_INIT;
      foreach (chooser[i]) chooser[i] = CTR_INIT;
      path_history = '0;
      gshare_guess = 1'b0;
      local_guess  = 1'b0;
   endfunction

   // advance the tables by one item; has_pred is set for a lookup
   function automatic void predict_direction(input kind_type k,
                                             input logic [BRANCH_ADDR_W-1:0] a,
                                             input logic t,
                                             output logic has_pred,
                                             output logic pred);
      logic [AIB-1:0]     slot;
      logic [GHB-1:0]     gidx;
      logic [AIB+LHB-1:0] lidx;
      int                 ch;
      slot     = a[AIB-1:0];
      gidx     = a[GHB-1:0] ^ path_history;
      lidx     = {slot, slot_history[slot]};
      has_pred = 1'b0;
      pred     = 1'b0;
      if (k == KIND_LOOKUP) begin
         gshare_guess = gshare_ctr[gidx] >= CTR_TAKEN;
         local_guess  = local_ctr[lidx] >= CTR_TAKEN;
         has_pred     = 1'b1;
         pred         = (chooser[slot] <= CHOOSE_GSHARE_MAX) ? gshare_guess : local_guess;
      end else begin
         ch = int'(chooser[slot]);
         if (t == gshare_guess) ch = ch - 1;
         if (t == local_guess) ch = ch + 1;
         if (ch < 0) ch = 0;
         if (ch > 7) ch = 7;
         chooser[slot]    = ctr_type'(ch);
         gshare_ctr[gidx] = saturate_step(gshare_ctr[gidx], t);
         local_ctr[lidx]  = saturate_step(local_ctr[lidx], t);
         path_history     = {path_history[GHB-2:0], t};
         slot_history[slot] = {slot_history[slot][LHB-2:0], t};
      end
   endfunction

   task automatic offer(input kind_type k, input logic [BRANCH_ADDR_W-1:0] a,
                        input logic t, input logic fixed, input logic fixed_pred);
      logic has_pred;
      logic pred;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.kind        <= k;
      req_if.branch_addr <= a;
      req_if.taken       <= t;
      do @(posedge clock); while (!req_if.ready);
      predict_direction(k, a, t, has_pred, pred);
      if (has_pred) pending_predictions.push_back(fixed ? fixed_pred : pred);
      items_accepted++;
   endtask

   function automatic logic stream_outcome(int b);
      logic out;
      case (stream_mode[b])
         0: out = $urandom_range(99) < 90;
         1: out = $urandom_range(99) < 10;
         2: out = (stream_iter[b] % stream_period[b]) != stream_period[b] - 1;
         default: out = stream_iter[b][0];
      endcase
      stream_iter[b]++;
      return out;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stalls, calm stretch, long hold-off
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_if.ready <= 1'b0;
      else if (calm) rsp_if.ready <= 1'b1;
      else rsp_if.ready <= $urandom_range(99) >= IDLE_PCT;
   end

   initial begin
      hold_rsp <= 1'b0;
      wait (items_accepted >= 250);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_predictions.size() == 0) begin
            if (bad_predictions < 10)
               $display("unexpected prediction %0b at cycle %0d",
                        rsp_if.prediction, cycle_count);
            bad_predictions++;
         end else begin
            want = pending_predictions.pop_front();
            if (rsp_if.prediction !== want) begin
               if (bad_predictions < 10)
                  $display("prediction mismatch at cycle %0d: expected %0b, got %0b",
                           cycle_count, want, rsp_if.prediction);
               bad_predictions++;
            end
         end
      end
   end

   initial begin
      int b;
      logic t;
      items_accepted     = 0;
      calm               <= 1'b0;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.kind        <= KIND_LOOKUP;
      req_if.branch_addr <= '0;
      req_if.taken       <= 1'b0;
      clear_tables();
      for (int i = 0; i < BRANCHES; i++) begin
         stream_addr[i]   = $urandom;
         stream_mode[i]   = $urandom_range(3);
         stream_period[i] = $urandom_range(8, 2);
         stream_iter[i]   = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].taken,
               directed_rows[i].fixed, directed_rows[i].fixed_pred);

      while (items_accepted < DIRECTED_ROWS + RANDOM_ITEMS) begin
         calm <= (items_accepted >= 450) && (items_accepted < 650);
         if ($urandom_range(99) < 15) begin
            // noise: lone lookups and updates anywhere
            offer(kind_type'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                  1'b0, 1'b0);
         end else begin
            b = $urandom_range(BRANCHES - 1);
            t = stream_outcome(b);
            offer(KIND_LOOKUP, stream_addr[b], 1'($urandom_range(1)), 1'b0, 1'b0);
            offer(KIND_UPDATE, stream_addr[b], t, 1'b0, 1'b0);
         end
      end
      req_if.valid <= 1'b0;
      calm         <= 1'b0;

      while (pending_predictions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (bad_predictions == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
